// ----- hdl/egkf_pkg.sv -----
// ----------------------------------------------------------------------------
// egkf_pkg
// Shared types and constants of the elevation grid height fusion block.
// ----------------------------------------------------------------------------
package egkf_pkg;

	// divider operand widths: 64-bit dividend, 33-bit divisor
	localparam int NUM_W = 64;
	localparam int DEN_W = 33;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_CELL_LOG2 = 3'd2,
		CFG_MIN_VAR   = 3'd3,
		CFG_MAX_VAR   = 3'd4,
		CFG_MIN_PVAR  = 3'd5,
		CFG_GATE_THR  = 3'd6
	} cfg_reg_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_INIT    = 3'd0,
		ST_FUSED   = 3'd1,
		ST_GATED   = 3'd2,
		ST_OUTSIDE = 3'd3,
		ST_SWEPT   = 3'd4
	} status_t;

	// control sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_GATE1,
		S_GATE2,
		S_DIVA,
		S_DIVB,
		S_DIVC,
		S_DIVD,
		S_SWEEP,
		S_SWEND,
		S_DONE
	} state_t;

	// one cell of the grid store
	typedef struct packed {
		logic        valid;
		logic [31:0] height;
		logic [31:0] variance;
	} cell_word_t;

endpackage

// ----- hdl/egkf_store.sv -----
// ----------------------------------------------------------------------------
// egkf_store
// Cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module egkf_store
	import egkf_pkg::*;
#(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  cell_word_t        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output cell_word_t        rdata
);

	cell_word_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, read data registered while re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/egkf_div.sv -----
// ----------------------------------------------------------------------------
// egkf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module egkf_div
	import egkf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo   <= num;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
			quo <= {quo[NUM_W-2:0], fits};
		end
	end

endmodule

// ----- hdl/elevation_grid_kalman_fusion.sv -----
// ----------------------------------------------------------------------------
// elevation_grid_kalman_fusion
// Fuses height points into a grid store with a gated scalar Kalman update.
// ----------------------------------------------------------------------------
// an outside point, an empty cell or a gated point ends without a divide; a fused
//   point waits on two passes of the bit-serial divider
// sweep: one cell read and written per cycle
// one word in flight at a time; the next is taken once the result is queued
// reset: a clearing pass over all GRID_COLS*GRID_ROWS cells marks every cell empty;
//   no word is taken during it, configuration writes are taken at any time
module elevation_grid_kalman_fusion
	import egkf_pkg::*;
#(
	parameter int GRID_COLS = 256,
	parameter int GRID_ROWS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_data,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // point_x, point_y, point_z, point_var
	input  logic [0:0]   s_tuser,  // func
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // cell_x, cell_y, cell_height, cell_variance
	output logic [2:0]   m_tuser   // status
);

	localparam int CELLS  = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELLS - 1);

	// configuration registers
	logic [31:0] org_x_q, org_y_q, minv_q, maxv_q, minpv_q;
	logic [4:0]  csl_q;
	logic [15:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			csl_q   <= 5'd13;
			minv_q  <= 32'd7;
			maxv_q  <= 32'd655;
			minpv_q <= 32'd66;
			thr_q   <= 16'd1280;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ORIGIN_X:  org_x_q <= cfg_data;
				CFG_ORIGIN_Y:  org_y_q <= cfg_data;
				CFG_CELL_LOG2: csl_q   <= cfg_data[4:0];
				CFG_MIN_VAR:   minv_q  <= cfg_data;
				CFG_MAX_VAR:   maxv_q  <= cfg_data;
				CFG_MIN_PVAR:  minpv_q <= cfg_data;
				CFG_GATE_THR:  thr_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [31:0] px, py, pz, pvar;
	assign px   = s_tdata[31:0];
	assign py   = s_tdata[63:32];
	assign pz   = s_tdata[95:64];
	assign pvar = s_tdata[127:96];

	// cell lookup
	logic signed [32:0] dx, dy;
	logic [31:0]        colsh, rowsh, pabs, pv_c;
	logic               outside;
	logic [ADDR_W-1:0]  idx_c;

	assign dx      = $signed({px[31], px}) - $signed({org_x_q[31], org_x_q});
	assign dy      = $signed({py[31], py}) - $signed({org_y_q[31], org_y_q});
	assign colsh   = dx[31:0] >> csl_q;
	assign rowsh   = dy[31:0] >> csl_q;
	assign outside = dx[32] || dy[32] || (colsh >= 32'(GRID_COLS))
		|| (rowsh >= 32'(GRID_ROWS));
	assign idx_c   = ADDR_W'(ADDR_W'(rowsh[ROW_W-1:0]) * ADDR_W'(GRID_COLS))
		+ ADDR_W'(colsh[COL_W-1:0]);

	// measurement variance: magnitude, floored
	assign pabs = pvar[31] ? (32'd0 - pvar) : pvar;
	assign pv_c = (pabs < minpv_q) ? minpv_q : pabs;

	// store and divider
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	cell_word_t        mem_wdata, mem_rdata;

	egkf_store #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] s_q;

	egkf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (s_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// working registers
	state_t            state_q, state_d;
	logic [ADDR_W-1:0] sw_q, sw_addr_s1, idx_q;
	logic              sw_pend_s1;
	logic [31:0]       z_q, pv_q, h_q, var_q, ad_q, step_q, thr2_q;
	logic              dneg_q;
	logic [63:0]       ad2_q, thrv_q, prod_q, prod2_q;
	logic [7:0]        cx_q, cy_q;
	status_t           res_st_q;
	logic [31:0]       res_h_q, res_v_q;
	logic              m_tvalid_q;
	logic [2:0]        m_tuser_q;
	logic [79:0]       m_tdata_q;
	logic              accept, out_free;
	logic [32:0]       d_c;
	logic [31:0]       newh, swv;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign d_c      = {z_q[31], z_q} - {mem_rdata.height[31], mem_rdata.height};
	assign newh     = dneg_q ? (h_q - step_q) : (h_q + step_q);

	// clamp for the sweep
	always_comb begin
		swv = mem_rdata.variance;
		if (mem_rdata.valid) begin
			if (swv < minv_q) begin
				swv = minv_q;
			end else if (swv > maxv_q) begin
				swv = maxv_q;
			end
		end
	end

	// sequencer: next state, memory and divider controls
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = idx_c;
		div_start = 1'b0;
		div_num   = prod_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sw_q;
				if (sw_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser[0]) begin
						state_d = S_SWEEP;
					end else if (outside) begin
						state_d = S_DONE;
					end else begin
						mem_re  = 1'b1;
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				if (!mem_rdata.valid) begin
					mem_we    = 1'b1;
					mem_wdata = '{valid: 1'b1, height: z_q, variance: pv_q};
					state_d   = S_DONE;
				end else begin
					state_d = S_GATE1;
				end
			end
			S_GATE1: state_d = S_GATE2;
			S_GATE2: begin
				if (ad2_q > thrv_q || s_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIVA;
				end
			end
			S_DIVA: begin
				div_start = 1'b1;
				state_d   = S_DIVB;
			end
			S_DIVB: begin
				if (div_done) begin
					state_d = S_DIVC;
				end
			end
			S_DIVC: begin
				div_start = 1'b1;
				div_num   = prod2_q;
				state_d   = S_DIVD;
			end
			S_DIVD: begin
				if (div_done) begin
					mem_we    = 1'b1;
					mem_wdata = '{valid: 1'b1, height: newh, variance: div_quo[31:0]};
					state_d   = S_DONE;
				end
			end
			S_SWEEP: begin
				mem_re    = 1'b1;
				mem_raddr = sw_q;
				if (sw_q == LAST) begin
					state_d = S_SWEND;
				end
			end
			S_SWEND: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// sweep write-back in the cycle after its read
		if (sw_pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = sw_addr_s1;
			mem_wdata = '{valid: mem_rdata.valid, height: mem_rdata.height, variance: swv};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			sw_q       <= '0;
			sw_pend_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sw_pend_s1 <= (state_q == S_SWEEP);
			if (state_q == S_CLEAR || state_q == S_SWEEP) begin
				sw_q <= (sw_q == LAST) ? '0 : sw_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		sw_addr_s1 <= sw_q;
		case (state_q)
			S_IDLE: begin
				z_q    <= pz;
				pv_q   <= pv_c;
				idx_q  <= idx_c;
				cx_q   <= outside ? 8'd0 : colsh[7:0];
				cy_q   <= outside ? 8'd0 : rowsh[7:0];
				thr2_q <= 32'(thr_q) * 32'(thr_q);
				res_st_q <= ST_OUTSIDE;
				res_h_q  <= '0;
				res_v_q  <= '0;
				if (s_tuser[0]) begin
					cx_q <= '0;
					cy_q <= '0;
				end
			end
			S_LOOK: begin
				h_q      <= mem_rdata.height;
				var_q    <= mem_rdata.variance;
				dneg_q   <= d_c[32];
				ad_q     <= d_c[32] ? 32'(-d_c) : d_c[31:0];
				res_st_q <= ST_INIT;
				res_h_q  <= z_q;
				res_v_q  <= pv_q;
			end
			S_GATE1: begin
				ad2_q  <= 64'(ad_q) * 64'(ad_q);
				thrv_q <= 64'(thr2_q) * 64'(var_q);
				s_q    <= {1'b0, var_q} + {1'b0, pv_q};
			end
			S_GATE2: begin
				prod_q   <= 64'(ad_q) * 64'(var_q);
				prod2_q  <= 64'(pv_q) * 64'(var_q);
				res_st_q <= (ad2_q > thrv_q) ? ST_GATED : ST_FUSED;
				res_h_q  <= h_q;
				res_v_q  <= var_q;
			end
			S_DIVB: begin
				if (div_done) begin
					step_q <= div_quo[31:0];
				end
			end
			S_DIVD: begin
				if (div_done) begin
					res_h_q <= newh;
					res_v_q <= div_quo[31:0];
				end
			end
			S_SWEND: begin
				res_st_q <= ST_SWEPT;
				res_h_q  <= '0;
				res_v_q  <= '0;
			end
			default: ;
		endcase
		// output register
		if (state_q == S_DONE && out_free) begin
			m_tuser_q <= res_st_q;
			m_tdata_q <= {res_v_q, res_h_q, cy_q, cx_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// a clearing write never marks a cell filled
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (mem_we && !mem_wdata.valid))
		else $error("clearing pass wrote a filled cell");

	// a word is taken only once per item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an item is in work");

	// sweep read and write-back never touch the same cell in one cycle
	a_sweep_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && mem_we) |-> (mem_raddr != mem_waddr))
		else $error("read and write to one cell in the same cycle");

	// the divider is started only while the sequencer waits for it
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == S_DIVB || state_q == S_DIVD))
		else $error("divider started outside a divide step");

endmodule
